### design/tlfcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfcl_pkg: shared types and constants for the tank level block
// Widths, fixed-point constants, register indexes, health codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlfcl_pkg;

    // Field widths
    localparam int UA_W       = 16;
    localparam int DIST_W     = 19;
    localparam int LVL_W      = 7;
    localparam int VOL_W      = 20;
    localparam int CNT_W      = 32;
    localparam int HLTH_W     = 2;
    localparam int SPAN_W     = 16;
    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 96;

    // Divider: dividend width and step counter width
    localparam int DIV_W     = 31;
    localparam int DIV_CNT_W = 5;

    // Loop current limits in microamps
    localparam logic [UA_W-1:0] CUR_MIN_UA  = 16'd3500;
    localparam logic [UA_W-1:0] CUR_MAX_UA  = 16'd22000;
    localparam logic [UA_W-1:0] CUR_ZERO_UA = 16'd4000;

    // Distance range in Q8 millimeters
    localparam logic [DIST_W-1:0] DIST_MIN_Q8 = 19'd51200;
    localparam logic [DIST_W-1:0] DIST_MAX_Q8 = 19'd512000;

    // Filter coefficient, Q16
    localparam logic [13:0] ALPHA_Q16 = 14'd13107;

    // Full scale percent in Q8
    localparam logic [PCT_W-1:0] PCT_FULL_Q8 = 15'd25600;

    // Reciprocal of 5: floor(y / 5) = (y * RECIP5) >> 22 for y < 2^22
    localparam logic [19:0] RECIP5       = 20'd838861;
    localparam int          RECIP5_SHIFT = 22;

    // Reciprocal of 100: floor(y / 100) = (y * RECIP100) >> 34 for y < 2^30
    localparam logic [27:0] RECIP100       = 28'd171798692;
    localparam int          RECIP100_SHIFT = 34;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 3'd4;

    // Configuration reset values
    localparam logic [15:0]      EMPTY_RST    = 16'd2000;
    localparam logic [15:0]      FULL_RST     = 16'd200;
    localparam logic [VOL_W-1:0] CAPACITY_RST = 20'd0;
    localparam logic [LVL_W-1:0] WARNING_RST  = 7'd80;
    localparam logic [LVL_W-1:0] CRITICAL_RST = 7'd90;

    // Health codes
    localparam logic [HLTH_W-1:0] HEALTH_OK       = 2'd0;
    localparam logic [HLTH_W-1:0] HEALTH_WARNING  = 2'd1;
    localparam logic [HLTH_W-1:0] HEALTH_CRITICAL = 2'd2;
    localparam logic [HLTH_W-1:0] HEALTH_OFFLINE  = 2'd3;

    // Controller states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLASS = 10'b0000000010,
        ST_DIST  = 10'b0000000100,
        ST_FILT  = 10'b0000001000,
        ST_UPD   = 10'b0000010000,
        ST_NUM   = 10'b0000100000,
        ST_DIV   = 10'b0001000000,
        ST_VOLA  = 10'b0010000000,
        ST_VOLB  = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } tlfcl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic bad_step;
        logic dist_mul;
        logic dist_fin;
        logic filt_mul;
        logic filt_upd;
        logic num_load;
        logic div_step;
        logic vol_mul;
        logic vol_scale;
        logic emit;
    } tlfcl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_ok;
        logic sample_good;
        logic bad_emit;
        logic div_skip;
        logic div_last;
        logic out_free;
    } tlfcl_status_t;

endpackage

### design/tank_level_from_current_loop_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_level_from_current_loop_core: tank level from a 4-20 mA loop sample
// A measured sample passes the 31-step percent divider; one sample is in work
// at a time, so the next input is taken only once the current one is done.
// Without a division (span or numerator not positive) the divider is skipped;
// offline results and dropped frames skip the arithmetic. An output stall holds work.
// Reset (rst_n low, asynchronous) restores the register defaults and clears
// the filter, the bad-sample run, the result count and the output valid flag.
// ----------------------------------------------------------------------------
module tank_level_from_current_loop_core
    import tlfcl_pkg::*;
#(
    parameter int BAD_LIMIT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [UA_W-1:0]       s_tdata,    // [15:0] loop_current_ua
    input  logic                  s_tuser,    // [0] frame_ok
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [6:0] fill_level, [26:7] volume_liters, [45:27] smoothed_distance_q8,
    // [61:46] echo_current_ua, [63:62] health, [95:64] result_count
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser     // [0] reading_good
);

    tlfcl_cmd_t    cmd;
    tlfcl_status_t status;

    tlfcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlfcl_dp #(
        .BAD_LIMIT (BAD_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending transfer");

    // An input transfer starts work: no second transfer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in work");

    // Offline results carry the offline health code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[63:62] == HEALTH_OFFLINE))
        else $error("offline result without offline health");

    // Measured results never carry the offline code and stay within 100 percent
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            ((m_tdata[63:62] != HEALTH_OFFLINE) && (m_tdata[6:0] <= 7'd100)))
        else $error("measured result out of range");

endmodule

### design/tlfcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfcl_ctrl: sequencing controller
// Walks one sample through classification, distance scaling, filtering,
// percent division, volume scaling and result transfer.
// ----------------------------------------------------------------------------
module tlfcl_ctrl
    import tlfcl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tlfcl_status_t status,
    output tlfcl_cmd_t    cmd
);

    tlfcl_state_t state_reg;
    tlfcl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (!status.frame_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.sample_good)
                begin
                    cmd.bad_step = 1'b1;
                    state_next   = status.bad_emit ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cmd.dist_mul = 1'b1;
                    state_next   = ST_DIST;
                end
            end
            ST_DIST:
            begin
                cmd.dist_fin = 1'b1;
                state_next   = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.filt_mul = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.filt_upd = 1'b1;
                state_next   = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num_load = 1'b1;
                state_next   = status.div_skip ? ST_VOLA : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_VOLA;
                end
            end
            ST_VOLA:
            begin
                cmd.vol_mul = 1'b1;
                state_next  = ST_VOLB;
            end
            ST_VOLB:
            begin
                cmd.vol_scale = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/tlfcl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfcl_dp: level datapath
// Configuration registers, sample capture, distance scaling, smoothing
// filter, restoring percent divider, volume scaling and output register.
// ----------------------------------------------------------------------------
module tlfcl_dp
    import tlfcl_pkg::*;
#(
    parameter int BAD_LIMIT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [UA_W-1:0]       s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    input  tlfcl_cmd_t            cmd,
    output tlfcl_status_t         status,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam int              BR_W     = $clog2(BAD_LIMIT + 1);
    localparam logic [BR_W-1:0] BR_LIMIT = BR_W'(BAD_LIMIT);

    // Configuration
    logic [15:0]      empty_reg;
    logic [15:0]      full_reg;
    logic [VOL_W-1:0] cap_reg;
    logic [LVL_W-1:0] warn_reg;
    logic [LVL_W-1:0] crit_reg;

    // Sample and running state
    logic                  ok_reg;
    logic [UA_W-1:0]       ua_reg;
    logic [BR_W-1:0]       bad_run_reg;
    logic [BR_W-1:0]       bad_run_next;
    logic                  seeded_reg;
    logic [DIST_W-1:0]     smooth_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [LVL_W-1:0]      last_level_reg;
    logic [VOL_W-1:0]      last_volume_reg;

    // Arithmetic pipeline registers
    logic [41:0]           dist_prod_reg;
    logic [DIST_W-1:0]     d_reg;
    logic signed [33:0]    filt_prod_reg;
    logic [SPAN_W-1:0]     span_reg;
    logic [SPAN_W-1:0]     div_rem_reg;
    logic [DIV_W-1:0]      div_quo_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PCT_W-1:0]      pct_reg;
    logic [34:0]           vol_prod_reg;
    logic [54:0]           vol_recip_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    // Combinational terms
    logic                  sample_good;
    logic [14:0]           x_ua;
    logic [21:0]           x_scaled;
    logic [19:0]           dist_raw;
    logic signed [19:0]    filt_diff;
    logic signed [17:0]    filt_step;
    logic signed [20:0]    filt_sum;
    logic signed [24:0]    pct_diff;
    logic signed [16:0]    span;
    logic                  div_skip;
    logic [DIV_W-1:0]      num_val;
    logic [SPAN_W:0]       div_trial;
    logic                  div_fit;
    logic [PCT_W-1:0]      pct_q8;
    logic [26:0]           vol_scaled;
    logic [VOL_W-1:0]      vol_val;
    logic [15:0]           level_sum;
    logic [LVL_W-1:0]      level_val;
    logic [HLTH_W-1:0]     health_val;
    logic [CNT_W-1:0]      count_inc;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= EMPTY_RST;
            full_reg  <= FULL_RST;
            cap_reg   <= CAPACITY_RST;
            warn_reg  <= WARNING_RST;
            crit_reg  <= CRITICAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EMPTY:    empty_reg <= cfg_wdata[15:0];
                REG_FULL:     full_reg  <= cfg_wdata[15:0];
                REG_CAPACITY: cap_reg   <= cfg_wdata[VOL_W-1:0];
                REG_WARNING:  warn_reg  <= cfg_wdata[LVL_W-1:0];
                REG_CRITICAL: crit_reg  <= cfg_wdata[LVL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Classify the captured sample
    assign sample_good  = (ua_reg >= CUR_MIN_UA) && (ua_reg <= CUR_MAX_UA);
    assign bad_run_next = (bad_run_reg < BR_LIMIT) ? (bad_run_reg + BR_W'(1)) : bad_run_reg;

    // Map current onto distance: (ua - 4000) * 144, then divide by 5
    assign x_ua     = (ua_reg > CUR_ZERO_UA) ? 15'(ua_reg - CUR_ZERO_UA) : 15'd0;
    assign x_scaled = 22'({x_ua, 7'd0}) + 22'({x_ua, 4'd0});
    assign dist_raw = 20'(dist_prod_reg >> RECIP5_SHIFT) + 20'(DIST_MIN_Q8);

    // Filter step, floored toward minus infinity by the arithmetic slice
    assign filt_diff = $signed({1'b0, d_reg}) - $signed({1'b0, smooth_reg});
    assign filt_step = filt_prod_reg[33:16];
    assign filt_sum  = $signed({2'b00, smooth_reg}) + 21'(filt_step);

    // Percent numerator and span
    assign pct_diff = $signed({1'b0, empty_reg, 8'd0}) - $signed({6'd0, smooth_reg});
    assign span     = $signed({1'b0, empty_reg}) - $signed({1'b0, full_reg});
    assign div_skip = span[16] || (span == 17'sd0) || pct_diff[24] || (pct_diff == 25'sd0);
    assign num_val  = DIV_W'(pct_diff[23:0]) * DIV_W'(100);

    // Restoring divider step
    assign div_trial = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_fit   = (div_trial >= {1'b0, span_reg});

    // Clamp percent, scale volume by 1/25600
    assign pct_q8     = (div_quo_reg > DIV_W'(PCT_FULL_Q8)) ? PCT_FULL_Q8 : div_quo_reg[PCT_W-1:0];
    assign vol_scaled = vol_prod_reg[34:8];
    assign vol_val    = VOL_W'(vol_recip_reg >> RECIP100_SHIFT);

    // Round percent half up and grade health, critical first
    assign level_sum = 16'(pct_reg) + 16'd128;
    assign level_val = level_sum[14:8];
    always_comb
    begin
        if (level_val >= crit_reg)
        begin
            health_val = HEALTH_CRITICAL;
        end
        else if (level_val >= warn_reg)
        begin
            health_val = HEALTH_WARNING;
        end
        else
        begin
            health_val = HEALTH_OK;
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    // Capture the sample and run the arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg <= s_tuser;
            ua_reg <= s_tdata;
        end
        if (cmd.dist_mul)
        begin
            dist_prod_reg <= 42'(x_scaled) * 42'(RECIP5);
        end
        if (cmd.dist_fin)
        begin
            d_reg <= (dist_raw > 20'(DIST_MAX_Q8)) ? DIST_MAX_Q8 : dist_raw[DIST_W-1:0];
        end
        if (cmd.filt_mul)
        begin
            filt_prod_reg <= 34'(filt_diff) * $signed({20'd0, ALPHA_Q16});
        end
        if (cmd.num_load)
        begin
            div_quo_reg <= div_skip ? '0 : num_val;
            div_rem_reg <= '0;
            span_reg    <= span[SPAN_W-1:0];
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_fit ? SPAN_W'(div_trial - {1'b0, span_reg})
                                   : div_trial[SPAN_W-1:0];
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_fit};
        end
        if (cmd.vol_mul)
        begin
            pct_reg      <= pct_q8;
            vol_prod_reg <= 35'(cap_reg) * 35'(pct_q8);
        end
        if (cmd.vol_scale)
        begin
            vol_recip_reg <= 55'(vol_scaled) * 55'(RECIP100);
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.num_load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Update bad run, filter state, history and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_run_reg     <= '0;
            seeded_reg      <= 1'b0;
            smooth_reg      <= '0;
            count_reg       <= '0;
            last_level_reg  <= '0;
            last_volume_reg <= '0;
        end
        else
        begin
            if (cmd.bad_step)
            begin
                bad_run_reg <= bad_run_next;
            end
            else if (cmd.dist_mul)
            begin
                bad_run_reg <= '0;
            end
            if (cmd.filt_upd)
            begin
                seeded_reg <= 1'b1;
                if (!seeded_reg)
                begin
                    smooth_reg <= d_reg;
                end
                else if (filt_sum[20])
                begin
                    smooth_reg <= '0;
                end
                else if (filt_sum[19:0] > 20'(DIST_MAX_Q8))
                begin
                    smooth_reg <= DIST_MAX_Q8;
                end
                else
                begin
                    smooth_reg <= filt_sum[DIST_W-1:0];
                end
            end
            if (cmd.emit)
            begin
                count_reg <= count_inc;
                if (sample_good)
                begin
                    last_level_reg  <= level_val;
                    last_volume_reg <= vol_val;
                end
            end
        end
    end

    // Output valid: set on emit, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (sample_good)
            begin
                out_data_reg <= {count_inc, health_val, ua_reg, smooth_reg, vol_val, level_val};
                out_user_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= {count_inc, HEALTH_OFFLINE, ua_reg, smooth_reg,
                                 last_volume_reg, last_level_reg};
                out_user_reg <= 1'b0;
            end
        end
    end

    assign status.frame_ok    = ok_reg;
    assign status.sample_good = sample_good;
    assign status.bad_emit    = (bad_run_next == BR_LIMIT);
    assign status.div_skip    = div_skip;
    assign status.div_last    = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
